/* rtl/core/assert_macros.svh */
// assertion helpers shared by the checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define AST_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define AST_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/vn3d_pkg.sv */
package vn3d_pkg;

  // pipeline layout
  localparam int SQRT_FIRST = 3;   // first square root stage
  localparam int SQRT_STAGES = 8;  // two result bits per stage
  localparam int DIV_FIRST = SQRT_FIRST + SQRT_STAGES;
  localparam int DIV_STAGES = 5;   // three quotient bits per stage
  localparam int DIV_BITS = 3;
  localparam int LAST_STAGE = DIV_FIRST + DIV_STAGES;
  localparam int NUM_STAGES = LAST_STAGE + 1;

  typedef struct packed {
    logic [2:0]        neg;
    logic [2:0][15:0]  mag;
    logic              zero;
    logic [2:0][30:0]  sq;
    logic [31:0]       rad;
    logic [17:0]       rem;
    logic [15:0]       root;
    logic [2:0][16:0]  drem;
    logic [2:0][14:0]  quot;
  } stage_t;

endpackage

/* rtl/core/vector_normalize_3d_core.sv */
// vector_normalize_3d_core: normalizes a signed Q8.8 3-vector to Q1.14 unit
// components and returns the integer length floor(sqrt(x^2+y^2+z^2)). One
// item is accepted per cycle while in_ready is high; out_valid rises as it
// enters the last of seventeen register stages (input capture, squaring, sum,
// eight square root stages at two bits each, five division stages at three
// quotient bits per component, sign fixup).
// The whole pipe advances together: it moves whenever the last stage is empty
// or its item is being taken, so a stall holds every item in place. An all
// zero vector gives zero_vector = 1 with zero units and zero magnitude.
module vector_normalize_3d_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] vec_x,
  input  logic signed [15:0] vec_y,
  input  logic signed [15:0] vec_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] unit_x,
  output logic signed [15:0] unit_y,
  output logic signed [15:0] unit_z,
  output logic        [15:0] magnitude,
  output logic               zero_vector
);
  import vn3d_pkg::*;

  stage_t                  pipe      [NUM_STAGES];
  stage_t                  pipe_next [NUM_STAGES];
  logic [NUM_STAGES-1:0]   vld;
  logic                    adv;

  // global advance: last stage empty or draining
  assign adv      = !vld[LAST_STAGE] || out_ready;
  assign in_ready = adv;

  always_comb begin
    logic [2:0][15:0] comp;
    logic [31:0] rad;
    logic [17:0] rem;
    logic [17:0] trial;
    logic [15:0] root;
    logic [16:0] dr;
    logic [14:0] q;
    logic [15:0] lenv;
    int          bitpos;
    comp = {vec_z, vec_y, vec_x};
    for (int s = 0; s < NUM_STAGES; s++) begin
      pipe_next[s] = (s == 0) ? pipe[0] : pipe[s-1];
      if (s == 0) begin
        // capture: sign and magnitude of each component
        for (int c = 0; c < 3; c++) begin
          pipe_next[0].neg[c] = comp[c][15];
          pipe_next[0].mag[c] = comp[c][15] ? 16'(-comp[c]) : comp[c];
        end
        pipe_next[0].zero = (vec_x == 16'sd0) && (vec_y == 16'sd0) && (vec_z == 16'sd0);
      end else if (s == 1) begin
        for (int c = 0; c < 3; c++) begin
          pipe_next[1].sq[c] = 31'(32'(pipe[0].mag[c]) * 32'(pipe[0].mag[c]));
        end
      end else if (s == 2) begin
        pipe_next[2].rad = 32'(pipe[1].sq[0]) + 32'(pipe[1].sq[1]) + 32'(pipe[1].sq[2]);
        pipe_next[2].rem = '0;
        pipe_next[2].root = '0;
      end else if (s < DIV_FIRST) begin
        // two square root iterations per stage
        rad  = pipe[s-1].rad;
        rem  = pipe[s-1].rem;
        root = pipe[s-1].root;
        for (int k = 0; k < 2; k++) begin
          rem   = {rem[15:0], rad[31:30]};
          rad   = {rad[29:0], 2'b00};
          trial = {root, 2'b01};
          if (rem >= trial) begin
            rem  = rem - trial;
            root = {root[14:0], 1'b1};
          end else begin
            root = {root[14:0], 1'b0};
          end
        end
        pipe_next[s].rad  = rad;
        pipe_next[s].rem  = rem;
        pipe_next[s].root = root;
      end else if (s < LAST_STAGE) begin
        // long division of mag*16384 by length, three bits per stage
        lenv = pipe[s-1].root;
        for (int c = 0; c < 3; c++) begin
          if (s == DIV_FIRST) begin
            dr = {2'b00, pipe[s-1].mag[c][15:1]};
            q  = '0;
          end else begin
            dr = pipe[s-1].drem[c];
            q  = pipe[s-1].quot[c];
          end
          for (int k = 0; k < DIV_BITS; k++) begin
            bitpos = 14 - (s - DIV_FIRST) * DIV_BITS - k;
            dr = {dr[15:0], (bitpos == 14) ? pipe[s-1].mag[c][0] : 1'b0};
            if (dr >= {1'b0, lenv}) begin
              dr = dr - {1'b0, lenv};
              q  = {q[13:0], 1'b1};
            end else begin
              q  = {q[13:0], 1'b0};
            end
          end
          pipe_next[s].drem[c] = dr;
          pipe_next[s].quot[c] = q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NUM_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        pipe[s] <= pipe_next[s];
      end
    end
  end

  // output stage: restore signs, force zeros for the zero vector
  logic signed [15:0] unit [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (pipe[LAST_STAGE-1].zero) begin
        unit[c] = '0;
      end else if (pipe[LAST_STAGE-1].neg[c]) begin
        unit[c] = 16'(-{1'b0, pipe[LAST_STAGE-1].quot[c]});
      end else begin
        unit[c] = {1'b0, pipe[LAST_STAGE-1].quot[c]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unit_x      <= unit[0];
      unit_y      <= unit[1];
      unit_z      <= unit[2];
      magnitude   <= pipe[LAST_STAGE-1].zero ? 16'd0 : pipe[LAST_STAGE-1].root;
      zero_vector <= pipe[LAST_STAGE-1].zero;
    end
  end

  assign out_valid = vld[LAST_STAGE];

endmodule

/* rtl/core/vn3d_checker.sv */
`include "assert_macros.svh"

module vn3d_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] unit_x,
  input logic signed [15:0] unit_y,
  input logic signed [15:0] unit_z,
  input logic        [15:0] magnitude,
  input logic               zero_vector
);
  // a stalled result holds
  `AST_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(magnitude) && $stable(unit_x))
  // input side stalls only behind a stalled result
  `AST_IMPLY(a_backpressure, clk, rst, !in_ready, out_valid && !out_ready)
  // zero vector gives all zero fields
  `AST_IMPLY(a_zero, clk, rst, out_valid && zero_vector, unit_x == 16'sd0 && unit_y == 16'sd0 && unit_z == 16'sd0 && magnitude == 16'd0)
  // any nonzero vector has nonzero length
  `AST_IMPLY(a_len, clk, rst, out_valid && !zero_vector, magnitude != 16'd0)
endmodule

bind vector_normalize_3d_core vn3d_checker u_vn3d_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .unit_x(unit_x),
  .unit_y(unit_y), .unit_z(unit_z), .magnitude(magnitude),
  .zero_vector(zero_vector)
);

/* tb/sv/tb_vector_normalize_3d_core.sv */
module tb_vector_normalize_3d_core;
  timeunit 1ns;
  timeprecision 1ps;

  // latency from acceptance to out_valid
  localparam int PIPE_DEPTH = 16;

  typedef struct packed {
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
    logic        [15:0] mag;
    logic               zero;
  } unit_vec_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] vec_x;
  logic signed [15:0] vec_y;
  logic signed [15:0] vec_z;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] unit_x;
  logic signed [15:0] unit_y;
  logic signed [15:0] unit_z;
  logic        [15:0] magnitude;
  logic               zero_vector;

  vector_normalize_3d_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
    .magnitude(magnitude), .zero_vector(zero_vector)
  );

  // expected normalized vectors, oldest first
  unit_vec_t pending_units[$];
  int        mismatches = 0;
  int        in_idle_pct = 38;   // sender gap odds in percent
  int        out_idle_pct = 38;  // receiver stall odds in percent
  int        hold_off = 0;       // cycles of forced receiver stall still to run

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // exact floor square root, bit by bit
  function automatic logic [31:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem = n;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[31:0];
  endfunction

  // c * 16384 / len, truncated toward zero
  function automatic logic signed [15:0] to_unit(input logic signed [15:0] c,
                                                 input logic [31:0] len);
    logic [31:0] cmag;
    logic [47:0] q;
    cmag = (c < 0) ? -32'(c) : 32'(c);
    q = (48'(cmag) * 48'd16384) / 48'(len);
    return (c < 0) ? -q[15:0] : q[15:0];
  endfunction

  function automatic unit_vec_t normalize(input logic signed [15:0] x,
                                          input logic signed [15:0] y,
                                          input logic signed [15:0] z);
    unit_vec_t r;
    logic [63:0] sumsq;
    logic [31:0] len;
    sumsq = 64'(32'(x) * 32'(x)) + 64'(32'(y) * 32'(y)) + 64'(32'(z) * 32'(z));
    r = '0;
    if (sumsq == 0) begin
      r.zero = 1'b1;
    end else begin
      len = floor_sqrt(sumsq);
      r.ux = to_unit(x, len);
      r.uy = to_unit(y, len);
      r.uz = to_unit(z, len);
      r.mag = len[15:0];
    end
    return r;
  endfunction

  // offer one vector, with a random gap first, and wait until it is taken
  task automatic send_vector(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    vec_x <= x;
    vec_y <= y;
    vec_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_units.push_back(normalize(x, y, z));
  endtask

  // receiver stalls at random, or for a counted hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // compare each taken result with the oldest expected vector
  always @(posedge clk) begin
    unit_vec_t exp_u;
    if (!rst && out_valid && out_ready) begin
      if (pending_units.size() == 0) begin
        $display("%0t: unexpected result ux=%0d uy=%0d uz=%0d mag=%0d zero=%0b",
                 $time, unit_x, unit_y, unit_z, magnitude, zero_vector);
        mismatches++;
      end else begin
        exp_u = pending_units.pop_front();
        if (unit_x !== exp_u.ux) begin
          $display("%0t: unit_x expected %0d actual %0d", $time, exp_u.ux, unit_x);
          mismatches++;
        end
        if (unit_y !== exp_u.uy) begin
          $display("%0t: unit_y expected %0d actual %0d", $time, exp_u.uy, unit_y);
          mismatches++;
        end
        if (unit_z !== exp_u.uz) begin
          $display("%0t: unit_z expected %0d actual %0d", $time, exp_u.uz, unit_z);
          mismatches++;
        end
        if (magnitude !== exp_u.mag) begin
          $display("%0t: magnitude expected %0d actual %0d", $time, exp_u.mag, magnitude);
          mismatches++;
        end
        if (zero_vector !== exp_u.zero) begin
          $display("%0t: zero_vector expected %0b actual %0b", $time, exp_u.zero,
                   zero_vector);
          mismatches++;
        end
      end
    end
  end

  // extremes, axes, the zero vector and two-dimensional vectors
  task automatic test_corners();
    send_vector(16'sd0, 16'sd0, 16'sd0);
    send_vector(16'sd1, 16'sd0, 16'sd0);
    send_vector(16'sd0, -16'sd1, 16'sd0);
    send_vector(16'sd0, 16'sd0, 16'sd1);
    send_vector(16'sh7fff, 16'sd0, 16'sd0);
    send_vector(16'sh8000, 16'sd0, 16'sd0);
    send_vector(16'sd0, 16'sh8000, 16'sd0);
    send_vector(16'sd0, 16'sd0, 16'sh8000);
    send_vector(16'sh8000, 16'sh8000, 16'sh8000);
    send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_vector(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_vector(16'sd256, 16'sd256, 16'sd0);
    send_vector(16'sd3, -16'sd4, 16'sd0);
    send_vector(-16'sd1, -16'sd1, -16'sd1);
    send_vector(16'sd1, 16'sh7fff, -16'sd1);
    send_vector(16'sd2, 16'sd3, 16'sd6);
    send_vector(-16'sd256, 16'sd0, 16'sd0);
    send_vector(16'sd0, 16'sd0, 16'sd0);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(4))
      0: return 16'($urandom_range(7)) - 16'sd3;  // tiny
      1: return $urandom_range(1) ? 16'sh7fff - 16'($urandom_range(3))
                                  : 16'sh8000 + 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  // random vectors, some two-dimensional, some all zero
  task automatic test_random(input int count);
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    for (int i = 0; i < count; i++) begin
      x = rand_comp();
      y = rand_comp();
      z = ($urandom_range(4) == 0) ? 16'sd0 : rand_comp();
      if ($urandom_range(40) == 0) begin
        x = '0;
        y = '0;
        z = '0;
      end
      send_vector(x, y, z);
    end
  endtask

  // back-to-back traffic with no idling on either side
  task automatic test_full_rate(input int count);
    in_idle_pct = 0;
    out_idle_pct = 0;
    test_random(count);
    in_idle_pct = 38;
    out_idle_pct = 38;
  endtask

  // receiver holds off long enough that the pipe fills and blocks the input
  task automatic test_backpressure(input int count);
    in_idle_pct = 0;
    hold_off <= 60;
    test_random(count);
    in_idle_pct = 38;
  endtask

  initial begin
    int drain;
    rst = 1'b1;
    in_valid = 1'b0;
    vec_x = '0;
    vec_y = '0;
    vec_z = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    test_random(500);
    test_full_rate(250);
    test_backpressure(50);
    test_random(250);
    in_valid <= 1'b0;
    drain = 0;
    while (pending_units.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (PIPE_DEPTH + 5) @(posedge clk);
    if (mismatches == 0 && pending_units.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (pending_units.size() != 0)
        $display("%0t: %0d results never arrived", $time, pending_units.size());
      $display("== FAIL ==");
    end
    $finish;
  end

  // overall limit
  initial begin
    #2ms;
    $display("timeout at %0t", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule
